[hw/rtl/npi_pkg.sv]
// Package: shared types, constants and helpers of the Neville interpolator.
package npi_pkg;

  localparam int MaxPoints = 8;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int WideW     = 48;
  localparam logic [3:0] NumPointsReset = 4'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpEval = 1'b1;

  typedef struct packed {
    logic               op;
    logic [2:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
  } npi_in_t;

  typedef struct packed {
    logic signed [31:0] result_y;
    logic               duplicate_x;
    logic               saturated;
  } npi_out_t;

  // divider control and status
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
  } npi_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } npi_div_rsp_t;

  localparam logic signed [WideW-1:0] WideMax = {1'b0, {(WideW-1){1'b1}}};
  localparam logic signed [WideW-1:0] WideMin = {1'b1, {(WideW-1){1'b0}}};

  // saturate a 50 bit signed value to 48 bits
  function automatic logic signed [WideW-1:0] sat_wide(input logic signed [WideW+1:0] v,
                                                       output logic s);
    s = 1'b0;
    if (v > $signed({{2{1'b0}}, WideMax})) begin
      s = 1'b1;
      return WideMax;
    end
    if (v < $signed({{2{1'b1}}, WideMin})) begin
      s = 1'b1;
      return WideMin;
    end
    return v[WideW-1:0];
  endfunction

  // magnitude with sign into a signed 48 bit value
  function automatic logic signed [WideW-1:0] signed_from(input logic [63:0] m,
                                                          input logic neg,
                                                          output logic s);
    logic [63:0] bound;
    logic [63:0] mm;
    bound = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
    mm = m;
    s = 1'b0;
    if (mm > bound) begin
      mm = bound;
      s = 1'b1;
    end
    return neg ? WideW'(-mm) : mm[WideW-1:0];
  endfunction

endpackage

[hw/rtl/npi_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, unsigned 64 / 33.
module npi_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  npi_pkg::npi_div_req_t req_i,
  output npi_pkg::npi_div_rsp_t rsp_o
);
  import npi_pkg::*;

  logic [63:0] quo_q, quo_d;
  logic [32:0] den_q, den_d;
  logic [33:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [33:0] trial;

  always_comb begin
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[32:0], quo_q[63]};
    if (req_i.start) begin
      quo_d = req_i.num;
      den_d = req_i.den;
      rem_d = '0;
      cnt_d = 7'd0;
      run_d = 1'b1;
    end else if (run_q) begin
      // shift in one numerator bit and try the subtract
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !run_q)
    else $error("divider done while running");
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |=> run_q)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !run_q |-> cnt_q == 7'd0 || done_q
                   || $past(done_q) || cnt_q == 7'd64)
    else $error("divider count off while idle");

endmodule

[hw/rtl/npi_mul.sv]
// Registered 48 x 48 magnitude multiplier built from 24 x 24 partial products.
module npi_mul (
  input  logic        clk_i,
  input  logic [47:0] a_i,
  input  logic [47:0] b_i,
  output logic [95:0] p_o
);
  import npi_pkg::*;

  logic [47:0] ll_q, lh_q, hl_q, hh_q;

  always_ff @(posedge clk_i) begin
    ll_q <= a_i[23:0]  * b_i[23:0];
    lh_q <= a_i[23:0]  * b_i[47:24];
    hl_q <= a_i[47:24] * b_i[23:0];
    hh_q <= a_i[47:24] * b_i[47:24];
  end

  always_ff @(posedge clk_i) begin
    p_o <= {hh_q, ll_q} + {24'd0, lh_q, 24'd0} + {24'd0, hl_q, 24'd0};
  end

endmodule

[hw/rtl/npi_ram.sv]
// Generic single-port-write, registered-read RAM.
module npi_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/neville_polynomial_interpolator_top.sv]
// Top level: point store, sequencer and shared divider of the Neville interpolator.
//
//  channel  | handshake          | word
//  ---------+--------------------+-------------------------------------
//  command  | start / busy       | in_i (op, point_index, x, y, query)
//  config   | cfg_valid_i/ready_o| cfg_data_i (num_points)
//  result   | result_valid_o     | result_o (result_y, dup, saturated)
//
// A load is taken and the block stays ready. An evaluation reads the n points,
// each through a read and a capture state, checks the n(n-1)/2 pairs for equal
// x at one per cycle and, unless a duplicate x is found or n = 1, then runs
// n(n-1)/2 tableau updates, each a setup state, a wait for the quotient of the
// shared divider, the two products on the shared multiplier and one store, plus
// a column step after each column. Reset is asynchronous and clears control
// only; the point store is not cleared. Busy is high from the start to the
// result strobe. The receiver cannot stall; the result is shown for one cycle.
module neville_polynomial_interpolator_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  npi_pkg::npi_in_t  in_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [3:0]        cfg_data_i,
  output logic              result_valid_o,
  output npi_pkg::npi_out_t result_o
);
  import npi_pkg::*;

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StRead  = 12'b000000000010,
    StCap   = 12'b000000000100,
    StDupA  = 12'b000000001000,
    StNear  = 12'b000000010000,
    StUpd   = 12'b000000100000,
    StDiv   = 12'b000001000000,
    StMul   = 12'b000010000000,
    StMulW  = 12'b000100000000,
    StStore = 12'b001000000000,
    StCol   = 12'b010000000000,
    StDone  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0] num_points_q;
  assign cfg_ready_o = 1'b1;

  // working copies of the used points
  logic signed [31:0]      xs_q [MaxPoints];
  logic signed [WideW-1:0] c_q  [MaxPoints];
  logic signed [WideW-1:0] d_q  [MaxPoints];
  logic signed [31:0]      y1_q;
  logic signed [31:0]      qx_q;
  logic [CntW-1:0]         n_q;
  logic [IdxW:0]           i_q, j_q, m_q, t_q;
  logic signed [WideW-1:0] y_q;
  logic signed [63:0]      best_q;
  logic                    sat_q, dup_q;
  logic signed [WideW-1:0] q_q;
  logic                    phase_q;   // 0: d product, 1: c product
  logic [2:0]              wait_q;
  logic [95:0]             pd_q;

  // point store
  logic [31:0] xr, yr;
  logic        we;
  assign we = start && !busy && in_i.op == OpLoad;

  npi_ram #(.Width(32), .Depth(MaxPoints)) u_xram (
    .clk_i, .we_i(we), .waddr_i(in_i.point_index[IdxW-1:0]), .wdata_i(in_i.point_x),
    .raddr_i(i_q[IdxW-1:0]), .rdata_o(xr));
  npi_ram #(.Width(32), .Depth(MaxPoints)) u_yram (
    .clk_i, .we_i(we), .waddr_i(in_i.point_index[IdxW-1:0]), .wdata_i(in_i.point_y),
    .raddr_i(i_q[IdxW-1:0]), .rdata_o(yr));

  // shared divider
  npi_div_req_t div_req;
  npi_div_rsp_t div_rsp;
  npi_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // shared multiplier
  logic [47:0] mul_a, mul_b;
  logic [95:0] mul_p;
  npi_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  // update operands for entry i at column m
  logic [IdxW-1:0]         ii, ip1, im;
  logic signed [WideW+1:0] w_raw;
  logic signed [WideW-1:0] w;
  logic                    w_s;
  logic signed [32:0]      den;
  logic signed [32:0]      ho, hp, hsel;
  logic [47:0]             wm;
  logic [32:0]             dm;
  assign ii  = i_q[IdxW-1:0];
  assign ip1 = IdxW'(i_q + 1'b1);
  assign im  = IdxW'(i_q + m_q);

  always_comb begin
    w_raw = {{2{c_q[ip1][WideW-1]}}, c_q[ip1]} - {{2{d_q[ii][WideW-1]}}, d_q[ii]};
    w     = sat_wide(w_raw, w_s);
    den   = {xs_q[ii][31], xs_q[ii]} - {xs_q[im][31], xs_q[im]};
    ho    = {xs_q[ii][31], xs_q[ii]} - {qx_q[31], qx_q};
    hp    = {xs_q[im][31], xs_q[im]} - {qx_q[31], qx_q};
    hsel  = phase_q ? ho : hp;
    wm    = w[WideW-1] ? 48'(-w) : w;
    dm    = den[32] ? 33'(-den) : den;
    mul_a = hsel[32] ? 48'(-{{15{hsel[32]}}, hsel}) : {15'd0, hsel};
    mul_b = q_q[WideW-1] ? 48'(-q_q) : q_q;
  end

  assign div_req.num   = {wm, 16'd0};
  assign div_req.den   = dm;
  assign div_req.start = state_q == StUpd;

  // nearest-point distance of the point being read
  logic signed [63:0] near_gap;
  always_comb begin
    near_gap = 64'(signed'({qx_q[31], qx_q}) - signed'({xr[31], xr}));
    if (near_gap < 0) near_gap = -near_gap;
  end

  logic [3:0]         np_eff;
  logic signed [WideW-1:0] qv, scv, ysum;
  logic               qs, ss, ys, ps_ovf;
  logic signed [WideW+1:0] yadd;
  logic               last_in_col;
  logic               col_adds_c;

  assign np_eff = (num_points_q == 4'd0) ? 4'd1 :
                  (num_points_q > 4'(MaxPoints)) ? 4'(MaxPoints) : num_points_q;
  assign last_in_col = (i_q + m_q + 1'b1) >= {1'b0, n_q};
  assign col_adds_c  = ({t_q, 1'b0}) < ({1'b0, n_q} - {1'b0, m_q});

  always_comb begin
    qv = signed_from(div_rsp.quo, w[WideW-1] != den[32], qs);
    ps_ovf = |pd_q[95:80];
    scv = signed_from(ps_ovf ? 64'h0000_8000_0000_0001 : pd_q[79:16],
                      hsel[32] != q_q[WideW-1] && (mul_b != 0) && (mul_a != 0), ss);
    yadd = col_adds_c ? {{2{y_q[WideW-1]}}, y_q} + {{2{c_q[t_q[IdxW-1:0]][WideW-1]}},
                                                   c_q[t_q[IdxW-1:0]]}
                      : {{2{y_q[WideW-1]}}, y_q} + {{2{d_q[IdxW'(t_q - 1'b1)][WideW-1]}},
                                                   d_q[IdxW'(t_q - 1'b1)]};
    ysum = sat_wide(yadd, ys);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start && in_i.op == OpEval) state_d = StRead;
      StRead:  state_d = StCap;
      StCap:   state_d = (i_q + 1'b1 >= {1'b0, n_q}) ? StDupA : StRead;
      StDupA:  if (j_q + 1'b1 >= {1'b0, n_q} && i_q + 2'd2 >= {1'b0, n_q}) begin
                 state_d = dup_q || (xs_q[ii] == xs_q[IdxW'(j_q)] && j_q > i_q) ? StDone
                         : (n_q == CntW'(1) ? StDone : StNear);
               end else if (n_q == CntW'(1)) state_d = StDone;
      StNear:  state_d = StUpd;
      StUpd:   state_d = StDiv;
      StDiv:   if (div_rsp.done) state_d = StMul;
      StMul:   state_d = StMulW;
      StMulW:  if (wait_q == 3'd2) state_d = phase_q ? StStore : StMul;
      StStore: state_d = last_in_col ? StCol : StUpd;
      StCol:   state_d = (m_q + 1'b1 >= {1'b0, n_q}) ? StDone : StUpd;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      num_points_q   <= NumPointsReset;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= state_q == StDone;
      if (cfg_valid_i && cfg_ready_o) num_points_q <= cfg_data_i;
    end
  end

  assign busy = state_q != StIdle;

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        n_q   <= CntW'(np_eff);
        qx_q  <= in_i.query_x;
        i_q   <= '0;
        sat_q <= 1'b0;
        dup_q <= 1'b0;
      end
      StRead: ;
      StCap: begin
        // capture the point just read and track the nearest one
        xs_q[ii] <= xr;
        c_q[ii]  <= WideW'(signed'(yr));
        d_q[ii]  <= WideW'(signed'(yr));
        if (ii == IdxW'(1)) y1_q <= yr;
        if (i_q == '0 || near_gap < best_q) begin
          best_q <= near_gap;
          t_q    <= i_q;
        end
        if (i_q + 1'b1 >= {1'b0, n_q}) begin
          i_q <= '0;
          j_q <= {{IdxW{1'b0}}, 1'b1};
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      StDupA: begin
        // one pair per cycle
        if (j_q > i_q && j_q < {1'b0, n_q} && xs_q[ii] == xs_q[IdxW'(j_q)]) dup_q <= 1'b1;
        if (j_q + 1'b1 >= {1'b0, n_q}) begin
          i_q <= i_q + 1'b1;
          j_q <= i_q + 2'd2;
        end else begin
          j_q <= j_q + 1'b1;
        end
        if (n_q == CntW'(1)) y_q <= c_q[0];
      end
      StNear: begin
        y_q <= c_q[t_q[IdxW-1:0]];
        m_q <= {{IdxW{1'b0}}, 1'b1};
        i_q <= '0;
      end
      StUpd: begin
        if (w_s) sat_q <= 1'b1;
        phase_q <= 1'b0;
      end
      StDiv: if (div_rsp.done) begin
        q_q <= (dm == 0) ? '0 : qv;
        if (qs && dm != 0) sat_q <= 1'b1;
        wait_q <= '0;
      end
      StMul: wait_q <= '0;
      StMulW: begin
        wait_q <= wait_q + 3'd1;
        pd_q   <= mul_p;
        if (wait_q == 3'd2) begin
          if (phase_q) c_q[ii] <= scv; else d_q[ii] <= scv;
          if (ss) sat_q <= 1'b1;
          phase_q <= 1'b1;
        end
      end
      StStore: begin
        i_q <= last_in_col ? '0 : i_q + 1'b1;
      end
      StCol: begin
        if (col_adds_c || t_q != '0) begin
          y_q <= ysum;
          if (ys) sat_q <= 1'b1;
        end
        if (!col_adds_c && t_q != '0) t_q <= t_q - 1'b1;
        m_q <= m_q + 1'b1;
      end
      StDone: begin
        if (dup_q) begin
          result_o.result_y    <= y1_q;
          result_o.duplicate_x <= 1'b1;
          result_o.saturated   <= 1'b0;
        end else begin
          result_o.duplicate_x <= 1'b0;
          if (y_q > 48'sd2147483647) begin
            result_o.result_y  <= 32'sh7FFF_FFFF;
            result_o.saturated <= 1'b1;
          end else if (y_q < -48'sd2147483648) begin
            result_o.result_y  <= 32'sh8000_0000;
            result_o.saturated <= 1'b1;
          end else begin
            result_o.result_y  <= y_q[31:0];
            result_o.saturated <= sat_q;
          end
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   result_valid_o |-> !$past(result_valid_o))
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   result_valid_o |-> $past(state_q) == StDone)
    else $error("result without a finished evaluation");
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_req.start |-> busy)
    else $error("divider started while idle");

endmodule

[dv/npi_result_checker.sv]
// Checker for the Neville interpolator: mirrors the point store, predicts and compares results.
`timescale 1ns / 1ps

module npi_result_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  npi_pkg::npi_in_t  in_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [3:0]        cfg_data_i,
  input  logic              result_valid_i,
  input  npi_pkg::npi_out_t result_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                eval_count_o,
  output int                dup_count_o,
  output int                sat_count_o
);
  import npi_pkg::*;

  localparam longint WMax = 64'sd140737488355327;
  localparam longint WMin = -64'sd140737488355328;
  localparam longint unsigned WMag = 64'd140737488355328;

  logic [31:0] x_store [MaxPoints];
  logic [31:0] y_store [MaxPoints];
  logic [3:0]  point_count;
  npi_out_t    want_q[$];
  bit          clip_seen;

  assign pending_o = want_q.size();

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint clip_wide(longint v);
    if (v > WMax) begin
      clip_seen = 1'b1;
      return WMax;
    end
    if (v < WMin) begin
      clip_seen = 1'b1;
      return WMin;
    end
    return v;
  endfunction

  function automatic longint apply_sign(longint unsigned m, bit neg);
    longint unsigned bound;
    bound = neg ? WMag : WMag - 1;
    if (m > bound) begin
      m = bound;
      clip_seen = 1'b1;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint slope_of(longint w, longint den);
    longint unsigned dm;
    dm = magn(den);
    if (dm == 0) return 0;
    return apply_sign((magn(w) << 16) / dm, (w < 0) != (den < 0));
  endfunction

  function automatic longint scaled(longint h, longint q);
    longint unsigned hm, qm;
    bit neg;
    hm  = magn(h);
    qm  = magn(q);
    neg = (h < 0) != (q < 0);
    if (hm != 0 && qm > 64'hFFFF_FFFF_FFFF_FFFF / hm) return apply_sign(WMag + 1, neg);
    return apply_sign((hm * qm) >> 16, neg);
  endfunction

  // Neville tableau starting from the point nearest the query
  function automatic npi_out_t interpolate(logic signed [31:0] query);
    longint xs[MaxPoints], c[MaxPoints], d[MaxPoints];
    longint qx, y, best, gap, ho, hp, w, q;
    bit dup;
    int n, t;
    npi_out_t r;
    clip_seen = 1'b0;
    dup = 1'b0;
    n = point_count;
    if (n < 1) n = 1;
    if (n > MaxPoints) n = MaxPoints;
    qx = query;
    for (int i = 0; i < n; i++) begin
      xs[i] = longint'($signed(x_store[i]));
      c[i]  = longint'($signed(y_store[i]));
      d[i]  = c[i];
    end
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (xs[i] == xs[j]) dup = 1'b1;
    if (dup) begin
      y = longint'($signed(y_store[1]));
    end else begin
      t = 0;
      best = magn(qx - xs[0]);
      for (int i = 1; i < n; i++) begin
        gap = magn(qx - xs[i]);
        if (gap < best) begin
          best = gap;
          t = i;
        end
      end
      y = c[t];
      for (int m = 1; m < n; m++) begin
        for (int i = 0; i < n - m; i++) begin
          ho = xs[i] - qx;
          hp = xs[i + m] - qx;
          w  = clip_wide(c[i + 1] - d[i]);
          q  = slope_of(w, xs[i] - xs[i + m]);
          d[i] = scaled(hp, q);
          c[i] = scaled(ho, q);
        end
        if (2 * t < n - m) begin
          y = clip_wide(y + c[t]);
        end else if (t > 0) begin
          y = clip_wide(y + d[t - 1]);
          t--;
        end
      end
      if (y > 64'sd2147483647) begin
        y = 64'sd2147483647;
        clip_seen = 1'b1;
      end
      if (y < -64'sd2147483648) begin
        y = -64'sd2147483648;
        clip_seen = 1'b1;
      end
    end
    r.result_y    = y[31:0];
    r.duplicate_x = dup;
    r.saturated   = dup ? 1'b0 : clip_seen;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    eval_count_o = 0;
    dup_count_o  = 0;
    sat_count_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count <= NumPointsReset;
      want_q.delete();
    end else begin
      npi_out_t w;
      if (cfg_valid_i && cfg_ready_i) point_count <= cfg_data_i;
      if (start_i && !busy_i) begin
        if (in_i.op == OpLoad) begin
          if (in_i.point_index < MaxPoints) begin
            x_store[in_i.point_index] <= in_i.point_x;
            y_store[in_i.point_index] <= in_i.point_y;
          end
        end else begin
          w = interpolate(in_i.query_x);
          want_q.push_back(w);
          eval_count_o++;
          if (w.duplicate_x) dup_count_o++;
          if (w.saturated) sat_count_o++;
        end
      end
      if (result_valid_i) begin
        if (want_q.size() == 0) begin
          report("unexpected result", result_i, 0);
        end else begin
          w = want_q.pop_front();
          if (result_i.result_y !== w.result_y) report("result_y", result_i.result_y, w.result_y);
          if (result_i.duplicate_x !== w.duplicate_x)
            report("duplicate_x", result_i.duplicate_x, w.duplicate_x);
          if (result_i.saturated !== w.saturated)
            report("saturated", result_i.saturated, w.saturated);
        end
      end
    end
  end

endmodule

[dv/neville_polynomial_interpolator_top_test.sv]
// Testbench top: drives points, queries and point counts into the interpolator and gives the verdict.
`timescale 1ns / 1ps

module neville_polynomial_interpolator_top_test;
  import npi_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  npi_in_t   in_w = '0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [3:0] cfg_data = '0;
  logic      result_valid;
  npi_out_t  result_w;

  int fails, pending, evals, dups, sats;
  int sent;
  bit no_idle;
  logic [31:0] x_shadow [MaxPoints];

  always #6 clk_i = ~clk_i;

  neville_polynomial_interpolator_top dut (
    .clk_i, .rst_ni, .start, .busy, .in_i(in_w),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .result_valid_o(result_valid), .result_o(result_w)
  );

  npi_result_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .in_i(in_w),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .result_valid_i(result_valid), .result_i(result_w),
    .fail_count_o(fails), .pending_o(pending), .eval_count_o(evals),
    .dup_count_o(dups), .sat_count_o(sats)
  );

  // Hold the word until busy is seen low mid-cycle; the next rising edge accepts it.
  task automatic send_word(npi_in_t w);
    bit ok;
    start <= 1'b1;
    in_w  <= w;
    forever begin
      @(negedge clk_i);
      ok = !busy;
      @(posedge clk_i);
      if (ok) break;
    end
    sent++;
    if (w.op == OpLoad) x_shadow[w.point_index] = w.point_x;
    // Now and then drop start for a random gap, except in the stretch with no idling.
    if (!no_idle && $urandom_range(0, 99) < 37) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic load_point(logic [2:0] slot, logic [31:0] x, logic [31:0] y);
    npi_in_t w;
    w = '0;
    w.op = OpLoad;
    w.point_index = slot;
    w.point_x = x;
    w.point_y = y;
    w.query_x = $urandom;
    send_word(w);
  endtask

  task automatic evaluate(logic [31:0] q);
    npi_in_t w;
    w = '0;
    w.op = OpEval;
    w.point_index = 3'($urandom);
    w.point_x = $urandom;
    w.point_y = $urandom;
    w.query_x = q;
    send_word(w);
  endtask

  // Pause the sender until every expected result is in and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    do @(negedge clk_i); while (pending != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the point count while idle.
  task automatic set_points(logic [3:0] n);
    bit ok;
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    forever begin
      @(negedge clk_i);
      ok = cfg_ready;
      @(posedge clk_i);
      if (ok) break;
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_x(int slot);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return ((slot * 3 - 10) <<< 16) + $urandom_range(0, 65535);
    if (r < 85) return $urandom;
    return x_shadow[$urandom_range(0, MaxPoints - 1)];
  endfunction

  function automatic logic [31:0] pick_y();
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_query();
    if ($urandom_range(0, 99) < 70) return $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
    return $urandom;
  endfunction

  initial begin
    int phase_len, r;
    logic [3:0] n;
    sent = 0;
    no_idle = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every slot first so no evaluation reads an unwritten entry.
    load_point(0, 32'h8000_0000, 32'h7FFF_FFFF);
    load_point(1, 32'h0001_0000, 32'h8000_0000);
    load_point(2, 32'h0002_0000, 32'h0000_0000);
    load_point(3, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 4; i < MaxPoints; i++) load_point(3'(i), 32'((i - 2) <<< 18), pick_y());
    evaluate(32'h0000_8000);               // default count of two
    set_points(4'd8);
    evaluate(32'h7FFF_FFFF);
    evaluate(32'h8000_0000);
    evaluate(32'h0000_0000);
    set_points(4'd1);
    evaluate(32'h1234_5678);
    set_points(4'd0);                       // zero count acts as one
    evaluate(32'hFFFF_0000);
    set_points(4'd15);                      // count above the store size clips
    evaluate(32'h0003_0000);
    load_point(3, 32'h8000_0000, 32'h0000_1000); // duplicate x in slots 0 and 3
    set_points(4'd4);
    evaluate(32'h0000_0000);
    load_point(3, 32'h0003_0000, 32'h0000_2000);
    evaluate(32'h0002_8000);

    // Random phases: a point count per phase, then mixed loads and queries.
    while (sent < 520) begin
      r = $urandom_range(0, 99);
      if (r < 3)       n = 4'd8;
      else if (r < 5)  n = 4'($urandom_range(9, 15));
      else if (r < 8)  n = 4'd0;
      else             n = 4'($urandom_range(1, 5));
      set_points(n);
      phase_len = $urandom_range(10, 40);
      no_idle = (sent > 200 && sent < 300);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 99) < 55) begin
          int s;
          s = $urandom_range(0, MaxPoints - 1);
          load_point(3'(s), pick_x(s), pick_y());
        end else begin
          evaluate(pick_query());
        end
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d words, %0d evaluations (%0d duplicate x, %0d saturated)",
             sent, evals, dups, sats);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 10000000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
